// ----- design/mcpt_pkg.sv -----
`default_nettype none

package mcpt_pkg;

    localparam int TIME_W    = 32;
    localparam int TAG_W     = 64;
    localparam int KIND_W    = 2;
    localparam int SLOT_W    = 4;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int RKIND_W   = 2;
    localparam int DIV_STEPS = 2;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
    localparam logic [OP_W-1:0] OP_REGISTER   = 2'd1;
    localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd2;

    localparam logic [RKIND_W-1:0] RSP_REGISTER   = 2'd0;
    localparam logic [RKIND_W-1:0] RSP_UNREGISTER = 2'd1;
    localparam logic [RKIND_W-1:0] RSP_FIRED      = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] period_ms;
        logic [TIME_W-1:0] elapsed_ms;
        logic [KIND_W-1:0] handler_kind;
        logic [TAG_W-1:0]  user_tag;
        logic [SLOT_W-1:0] slot_in;
    } mcpt_req_t;

    typedef struct packed {
        logic [RKIND_W-1:0]  kind;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [KIND_W-1:0]   fired_kind;
        logic [TAG_W-1:0]    fired_tag;
        logic                last;
    } mcpt_rsp_t;

    // per-slot payload, only meaningful while the slot is active
    typedef struct packed {
        logic [TIME_W-1:0] reload;
        logic [TIME_W-1:0] count;
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
    } mcpt_slot_t;

    typedef struct packed {
        logic       active;
        mcpt_slot_t data;
    } mcpt_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_FLUSH
    } mcpt_state_t;

endpackage

`default_nettype wire

// ----- design/mcpt_div.sv -----
`default_nettype none

// Divide by a constant through a reciprocal multiply. With L = clog2(D) the
// scaled reciprocal ceil(2^(32+L) / D) lies in [2^32, 2^33), so only its low
// word is multiplied; the quotient is exact for every 32-bit dividend.
// Two steps: product, then add the implied top word and shift.
module mcpt_div
    import mcpt_pkg::*;
#(
    parameter int DIVISOR = 1
)
(
    input  wire logic              clk,
    input  wire logic              load,
    input  wire logic              step,
    input  wire logic [TIME_W-1:0] dividend,
    output logic      [TIME_W-1:0] quotient
);

    localparam int PW = 2 * TIME_W;
    localparam int SH = TIME_W + $clog2(DIVISOR);
    localparam logic [PW-1:0] RECIP =
        ((PW'(1) << SH) + PW'(DIVISOR) - PW'(1)) / PW'(DIVISOR);
    localparam logic [TIME_W-1:0] RECIP_LO = RECIP[TIME_W-1:0];

    logic [TIME_W-1:0] x_reg;
    logic [PW-1:0]     prod_reg;
    logic [PW-1:0]     prod_next;
    logic [PW:0]       sum;
    logic [TIME_W-1:0] q_reg;
    logic [TIME_W-1:0] q_next;

    always_comb
    begin
        prod_next = PW'(x_reg) * PW'(RECIP_LO);
        sum       = {1'b0, x_reg, TIME_W'(0)} + {1'b0, prod_reg};
        q_next    = TIME_W'(sum >> SH);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= dividend;
        end
        else if (step)
        begin
            prod_reg <= prod_next;
            q_reg    <= q_next;
        end
    end

    assign quotient = q_reg;

endmodule

`default_nettype wire

// ----- design/mcpt_cell.sv -----
`default_nettype none

// One slot of the ring; takes its neighbour's entry on every shift.
module mcpt_cell
    import mcpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        shift,
    input  wire mcpt_entry_t d,
    output mcpt_entry_t      q
);

    logic       active_reg;
    mcpt_slot_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (shift)
        begin
            active_reg <= d.active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d.data;
        end
    end

    assign q.active = active_reg;
    assign q.data   = data_reg;

endmodule

`default_nettype wire

// ----- design/multi_channel_periodic_timer_unit.sv -----
`default_nettype none

// Multi-channel periodic tick timer.
// Request channel (req_valid/req_ready/req) takes one beat per command:
// tick, register channel or unregister channel. Response channel
// (rsp_valid/rsp_ready/rsp) returns one beat per reply or per channel firing;
// the final beat of a command carries last. A tick with no firing gives none.
// The slot table is a ring of SLOTS cells that rotates by one cell per cycle
// past a single head update; every tick, unregister and register with a period
// of at least one step makes one full turn, so the table is back in slot order
// whenever the block is idle. A register first runs the reciprocal-multiply
// divide by STEP_MS (period and first countdown in parallel) before its turn.
// A register with a period below one step skips the divide and the turn and
// goes straight to the flush step, which answers it with STATUS_INVALID.
// Firings leave in ascending slot order through a one-deep hold register and
// the response register; when the receiver stalls with both full, the ring
// stops turning until a beat is taken. A new command may be accepted while
// the last response still waits in the output register.
// Reset clears all slot active flags, the channel count and the control
// state; slot payloads are written when a slot is claimed.
module multi_channel_periodic_timer_unit
    import mcpt_pkg::*;
#(
    parameter int SLOTS   = 16,
    parameter int STEP_MS = 1
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire mcpt_req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output mcpt_rsp_t      rsp
);

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW   = $clog2(SLOTS + 1);
    localparam int IDXW = (IW > SLOT_W) ? IW : SLOT_W;

    // ring of cells
    mcpt_entry_t cell_q [SLOTS];
    mcpt_entry_t cell_d [SLOTS];
    logic [SLOTS-1:0] active_vec;

    // control state
    mcpt_state_t state_reg;
    mcpt_state_t state_next;
    logic [IW-1:0]     idx_reg;
    logic [DIV_CW-1:0] dcnt_reg;
    logic [TW-1:0]     total_reg;
    logic              found_reg;
    logic              hit_reg;
    logic              bad_reg;
    logic              held_valid_reg;
    logic              out_valid_reg;

    // command payload
    logic [OP_W-1:0]   op_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SLOT_W-1:0] slot_in_reg;
    logic [SLOT_W-1:0] found_slot_reg;
    mcpt_rsp_t         held_reg;
    mcpt_rsp_t         out_reg;

    logic [TIME_W-1:0] first_diff;
    logic [TIME_W-1:0] q_period;
    logic [TIME_W-1:0] q_first;

    // head update
    mcpt_entry_t head;
    mcpt_entry_t head_next;
    logic        fire;
    logic        claim;
    logic        drop;

    // per-cycle controls
    logic      accept;
    logic      out_free;
    logic      shift;
    logic      div_step;
    logic      held_load;
    logic      held_clear;
    logic      out_load;
    logic      scan_end;
    mcpt_rsp_t out_next;
    mcpt_rsp_t fire_rsp;
    mcpt_rsp_t final_rsp;

    assign accept   = req_valid && req_ready;
    assign out_free = !out_valid_reg || rsp_ready;
    assign scan_end = shift && (idx_reg == IW'(SLOTS - 1));

    // remaining time to first expiry, before scaling by the step
    assign first_diff = (req.elapsed_ms >= req.period_ms) ? '0
                        : (req.period_ms - req.elapsed_ms);

    mcpt_div #(.DIVISOR(STEP_MS)) u_div_period (
        .clk      (clk),
        .load     (accept),
        .step     (div_step),
        .dividend (req.period_ms),
        .quotient (q_period)
    );

    mcpt_div #(.DIVISOR(STEP_MS)) u_div_first (
        .clk      (clk),
        .load     (accept),
        .step     (div_step),
        .dividend (first_diff),
        .quotient (q_first)
    );

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            if (g == SLOTS - 1)
            begin : g_tail
                assign cell_d[g] = head_next;
            end
            else
            begin : g_link
                assign cell_d[g] = cell_q[g + 1];
            end

            mcpt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (cell_d[g]),
                .q     (cell_q[g])
            );

            assign active_vec[g] = cell_q[g].active;
        end
    endgenerate

    // head cell: count down, claim or release as the entry passes
    always_comb
    begin
        head      = cell_q[0];
        head_next = head;
        fire      = 1'b0;
        claim     = 1'b0;
        drop      = 1'b0;
        case (op_reg)
            OP_TICK:
            begin
                if (head.active)
                begin
                    if (head.data.count > TIME_W'(1))
                    begin
                        head_next.data.count = head.data.count - TIME_W'(1);
                    end
                    else
                    begin
                        head_next.data.count = head.data.reload;
                        fire                 = 1'b1;
                    end
                end
            end
            OP_REGISTER:
            begin
                if (!found_reg && !head.active && (total_reg < TW'(SLOTS)))
                begin
                    head_next.active      = 1'b1;
                    head_next.data.reload = q_period;
                    head_next.data.count  = q_first;
                    head_next.data.kind   = kind_reg;
                    head_next.data.tag    = tag_reg;
                    claim                 = 1'b1;
                end
            end
            OP_UNREGISTER:
            begin
                if (head.active && (IDXW'(idx_reg) == IDXW'(slot_in_reg)))
                begin
                    head_next.active = 1'b0;
                    drop             = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        fire_rsp            = '0;
        fire_rsp.kind       = RSP_FIRED;
        fire_rsp.status     = STATUS_OK;
        fire_rsp.slot_out   = SLOT_W'(idx_reg);
        fire_rsp.fired_kind = head.data.kind;
        fire_rsp.fired_tag  = head.data.tag;
        fire_rsp.last       = 1'b0;

        final_rsp      = '0;
        final_rsp.last = 1'b1;
        if (op_reg == OP_REGISTER)
        begin
            final_rsp.kind = RSP_REGISTER;
            if (bad_reg)
            begin
                final_rsp.status = STATUS_INVALID;
            end
            else if (!found_reg)
            begin
                final_rsp.status = STATUS_FULL;
            end
            else
            begin
                final_rsp.status   = STATUS_OK;
                final_rsp.slot_out = found_slot_reg;
            end
        end
        else
        begin
            final_rsp.kind     = RSP_UNREGISTER;
            final_rsp.status   = hit_reg ? STATUS_OK : STATUS_INVALID;
            final_rsp.slot_out = slot_in_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((req.op == OP_TICK) || (req.op == OP_UNREGISTER))
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req.op == OP_REGISTER)
                    begin
                        state_next = (req.period_ms < TIME_W'(STEP_MS)) ? ST_FLUSH
                                     : ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (dcnt_reg == DIV_CW'(DIV_STEPS - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (op_reg == OP_TICK)
                begin
                    if (!held_valid_reg || out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        req_ready  = 1'b0;
        div_step   = 1'b0;
        shift      = 1'b0;
        held_load  = 1'b0;
        held_clear = 1'b0;
        out_load   = 1'b0;
        out_next   = held_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_DIV:
            begin
                div_step = 1'b1;
            end
            ST_SCAN:
            begin
                // a second firing needs room to push the held one out
                shift = !(fire && held_valid_reg && !out_free);
                if (shift && fire)
                begin
                    held_load = 1'b1;
                    out_load  = held_valid_reg;
                end
            end
            ST_FLUSH:
            begin
                if (op_reg == OP_TICK)
                begin
                    if (held_valid_reg && out_free)
                    begin
                        out_load      = 1'b1;
                        out_next.last = 1'b1;
                        held_clear    = 1'b1;
                    end
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    out_next = final_rsp;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            dcnt_reg       <= '0;
            total_reg      <= '0;
            found_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            bad_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                idx_reg   <= '0;
                dcnt_reg  <= '0;
                found_reg <= 1'b0;
                hit_reg   <= 1'b0;
                bad_reg   <= (req.period_ms < TIME_W'(STEP_MS));
            end
            else
            begin
                if (div_step)
                begin
                    dcnt_reg <= dcnt_reg + DIV_CW'(1);
                end
                if (shift)
                begin
                    idx_reg <= scan_end ? '0 : (idx_reg + IW'(1));
                end
                if (shift && claim)
                begin
                    found_reg <= 1'b1;
                    total_reg <= total_reg + TW'(1);
                end
                if (shift && drop)
                begin
                    hit_reg   <= 1'b1;
                    total_reg <= total_reg - TW'(1);
                end
            end

            if (held_load)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (held_clear)
            begin
                held_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= req.op;
            kind_reg    <= req.handler_kind;
            tag_reg     <= req.user_tag;
            slot_in_reg <= req.slot_in;
        end
        if (shift && claim)
        begin
            found_slot_reg <= SLOT_W'(idx_reg);
        end
        if (held_load)
        begin
            held_reg <= fire_rsp;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // channel count matches the active flags whenever the ring is at rest
    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (total_reg == TW'($countones(active_vec))))
        else $error("channel count out of step with active slots");

    // hold register only carries a firing during a tick
    a_held_only_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (((state_reg == ST_SCAN) || (state_reg == ST_FLUSH))
                            && (op_reg == OP_TICK)))
        else $error("held firing outside a tick");

    // a full turn of the ring always ends in the flush step
    a_turn_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && scan_end) |=> (state_reg == ST_FLUSH))
        else $error("scan did not end after one full turn");

endmodule

`default_nettype wire
